[design/lnsu_pkg.sv]
package lnsu_pkg;

    localparam int VALUE_W     = 32;
    localparam int FRAC_W      = 16;
    localparam int DECAY_W     = FRAC_W + 1;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int REG_INDEX_W = 3;
    localparam int SUM_W       = VALUE_W + 4;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic [DECAY_W-1:0]        decay_t;
    typedef logic [MODE_W-1:0]         mode_t;
    typedef logic [STATUS_W-1:0]       status_t;
    typedef logic [REG_INDEX_W-1:0]    reg_index_t;

    localparam reg_index_t REG_BIAS       = 3'd0;
    localparam reg_index_t REG_FIRE_THR   = 3'd1;
    localparam reg_index_t REG_LOW_THR    = 3'd2;
    localparam reg_index_t REG_FIRE_LEVEL = 3'd3;
    localparam reg_index_t REG_LOW_LEVEL  = 3'd4;
    localparam reg_index_t REG_DECAY      = 3'd5;
    localparam reg_index_t REG_FIRE_MODE  = 3'd6;
    localparam reg_index_t REG_LOW_MODE   = 3'd7;

    localparam mode_t FIRE_NONE = 2'd0;
    localparam mode_t FIRE_SOFT = 2'd1;
    localparam mode_t FIRE_HARD = 2'd2;
    localparam mode_t FIRE_KEEP = 2'd3;

    localparam mode_t LOW_NONE = 2'd0;
    localparam mode_t LOW_SOFT = 2'd1;
    localparam mode_t LOW_HARD = 2'd2;
    localparam mode_t LOW_SAT  = 2'd3;

    localparam status_t STATUS_IDLE    = 2'd0;
    localparam status_t STATUS_UPDATED = 2'd1;
    localparam status_t STATUS_FIRED   = 2'd2;

    localparam value_t FIXED_ONE     = value_t'(1) <<< FRAC_W;
    localparam value_t FIXED_NEG_ONE = -FIXED_ONE;
    localparam decay_t DECAY_ONE     = decay_t'(1) << FRAC_W;

    localparam sum_t SAT_MAX = {{(SUM_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
    localparam sum_t SAT_MIN = {{(SUM_W-VALUE_W+1){1'b1}}, {(VALUE_W-1){1'b0}}};

    typedef struct packed {
        value_t bias_value;
        value_t fire_threshold;
        value_t low_threshold;
        value_t fire_reset_level;
        value_t low_reset_level;
        decay_t decay_factor;
        mode_t  fire_reset_mode;
        mode_t  low_reset_mode;
    } cfg_t;

    function automatic value_t sat_value(input sum_t v);
        value_t r;
        if (v > SAT_MAX)
            r = SAT_MAX[VALUE_W-1:0];
        else if (v < SAT_MIN)
            r = SAT_MIN[VALUE_W-1:0];
        else
            r = v[VALUE_W-1:0];
        return r;
    endfunction

endpackage

[design/lnsu_cfg_regs.sv]
module lnsu_cfg_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  lnsu_pkg::reg_index_t cfg_index,
    input  lnsu_pkg::value_t     cfg_data,
    output lnsu_pkg::cfg_t       cfg
);
    import lnsu_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bias_value       <= '0;
            cfg_reg.fire_threshold   <= FIXED_ONE;
            cfg_reg.low_threshold    <= FIXED_NEG_ONE;
            cfg_reg.fire_reset_level <= '0;
            cfg_reg.low_reset_level  <= '0;
            cfg_reg.decay_factor     <= DECAY_ONE;
            cfg_reg.fire_reset_mode  <= FIRE_NONE;
            cfg_reg.low_reset_mode   <= LOW_NONE;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_BIAS:       cfg_reg.bias_value       <= cfg_data;
                REG_FIRE_THR:   cfg_reg.fire_threshold   <= cfg_data;
                REG_LOW_THR:    cfg_reg.low_threshold    <= cfg_data;
                REG_FIRE_LEVEL: cfg_reg.fire_reset_level <= cfg_data;
                REG_LOW_LEVEL:  cfg_reg.low_reset_level  <= cfg_data;
                REG_DECAY:      cfg_reg.decay_factor     <= cfg_data[DECAY_W-1:0];
                REG_FIRE_MODE:  cfg_reg.fire_reset_mode  <= cfg_data[MODE_W-1:0];
                REG_LOW_MODE:   cfg_reg.low_reset_mode   <= cfg_data[MODE_W-1:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/lnsu_soma.sv]
module lnsu_soma (
    input  lnsu_pkg::cfg_t    cfg,
    input  lnsu_pkg::value_t  potential,
    input  lnsu_pkg::value_t  current,
    output lnsu_pkg::status_t status,
    output lnsu_pkg::value_t  potential_next
);
    import lnsu_pkg::*;

    localparam int PROD_W = VALUE_W + DECAY_W + 1;
    localparam int LEAK_W = VALUE_W + 2;

    logic signed [PROD_W-1:0] product;
    logic signed [PROD_W-1:0] product_shift;
    logic signed [LEAK_W-1:0] leaked;
    sum_t   integ_sum;
    value_t integ;
    logic   fire;
    value_t after_fire;
    sum_t   fire_diff;
    sum_t   low_diff;

    always_comb
    begin
        // signed potential times unsigned Q1.16 decay, floor shift
        product       = PROD_W'(potential) * $signed({1'b0, cfg.decay_factor});
        product_shift = product >>> FRAC_W;
        leaked        = product_shift[LEAK_W-1:0];
        integ_sum     = SUM_W'(leaked) + SUM_W'(current) + SUM_W'(cfg.bias_value);
        integ         = sat_value(integ_sum);

        if (integ != '0 || cfg.bias_value != '0)
            status = STATUS_UPDATED;
        else
            status = STATUS_IDLE;

        if (cfg.bias_value != '0)
            fire = integ > cfg.fire_threshold;
        else
            fire = integ >= cfg.fire_threshold;

        fire_diff  = SUM_W'(integ) - SUM_W'(cfg.fire_threshold);
        after_fire = integ;
        if (fire)
        begin
            status = STATUS_FIRED;
            unique case (cfg.fire_reset_mode)
                FIRE_HARD: after_fire = cfg.fire_reset_level;
                FIRE_SOFT: after_fire = sat_value(fire_diff);
                FIRE_NONE, FIRE_KEEP: after_fire = integ;
                default: after_fire = integ;
            endcase
        end

        low_diff       = SUM_W'(after_fire) - SUM_W'(cfg.low_threshold);
        potential_next = after_fire;
        if (after_fire < cfg.low_threshold)
        begin
            unique case (cfg.low_reset_mode)
                LOW_SOFT: potential_next = sat_value(low_diff);
                LOW_HARD: potential_next = cfg.low_reset_level;
                LOW_SAT:  potential_next = cfg.low_threshold;
                LOW_NONE: potential_next = after_fire;
                default:  potential_next = after_fire;
            endcase
        end
    end

endmodule

[design/lif_neuron_soma_update.sv]
// channel | handshake            | payload
// in      | in_valid / in_ready  | input_current
// out     | out_valid / out_ready| spike_status, new_potential
// cfg     | cfg_write_en         | cfg_index, cfg_data
//
// One item per cycle unless out_ready stalls; the result is registered.
// Rate is set by the potential feedback through the decay multiply, add and
// reset logic, all done in the cycle the item leaves the input register.
// Reset clears the potential to zero and the config registers to their defaults.
// A stalled result holds the item in the input register; in_ready drops only
// when both registers are full and out_ready is low.
module lif_neuron_soma_update (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  lnsu_pkg::reg_index_t cfg_index,
    input  lnsu_pkg::value_t     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lnsu_pkg::value_t     input_current,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lnsu_pkg::status_t    spike_status,
    output lnsu_pkg::value_t     new_potential
);
    import lnsu_pkg::*;

    cfg_t    cfg;
    logic    in_valid_reg;
    value_t  current_reg;
    value_t  potential_reg;
    value_t  potential_next;
    status_t status_next;
    logic    out_valid_reg;
    status_t status_reg;
    value_t  result_reg;
    logic    advance;

    lnsu_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    lnsu_soma u_soma (
        .cfg            (cfg),
        .potential      (potential_reg),
        .current        (current_reg),
        .status         (status_next),
        .potential_next (potential_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            potential_reg <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                potential_reg <= potential_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            current_reg <= input_current;
        if (advance)
        begin
            status_reg <= status_next;
            result_reg <= potential_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign spike_status  = status_reg;
    assign new_potential = result_reg;

endmodule
